>>> hw/rtl/lpc_pkg.sv
// lpc_pkg: shared widths, register indexes and effect codes of the layer compositor
// no dependencies; imported by layer_priority_compositor_top
package lpc_pkg;

    localparam int COLOR_W     = 15;
    localparam int NUM_BG      = 4;
    localparam int NUM_OBJ     = 4;
    localparam int NUM_CAND    = NUM_BG + NUM_OBJ;
    localparam int PRIO_W      = 2;
    localparam int PIXEL_W     = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int KEY_W       = 6;
    localparam int LAYER_W     = 3;

    localparam logic [4:0] COEF_MAX     = 5'd16;
    localparam logic [7:0] FULL8        = 8'd255;
    localparam logic [2:0] SPRITE_LAYER = 3'd4;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_CONTROL    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ALPHA      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_BRIGHTNESS = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKDROP_COLOR   = 8'd3;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_ALPHA    = 2'd1,
        MODE_BRIGHTEN = 2'd2,
        MODE_DARKEN   = 2'd3
    } t_effect;

endpackage

>>> hw/rtl/layer_priority_compositor_top.sv
// layer_priority_compositor_top: priority selection of eight layer pixels plus
// alpha blend / brighten / darken of the winner; depends on lpc_pkg
// path: an input transfer loads the input register, then selection and effect logic
// load the result register; a stalled full result stage holds both
// throughput: one pixel per cycle unless stalled; single-pass logic between the two registers
// reset: synchronous, active low; clears both valid flags and all configuration registers
module layer_priority_compositor_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [lpc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input pixel channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lpc_pkg::NUM_BG*lpc_pkg::COLOR_W-1:0]  i_bg_colors,
    input  logic [lpc_pkg::NUM_BG*lpc_pkg::PRIO_W-1:0]   i_bg_priorities,
    input  logic [lpc_pkg::NUM_BG-1:0]                   i_bg_opaque,
    input  logic [lpc_pkg::NUM_OBJ*lpc_pkg::COLOR_W-1:0] i_obj_colors,
    input  logic [lpc_pkg::NUM_OBJ-1:0]                  i_obj_opaque,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lpc_pkg::PIXEL_W-1:0]         o_pixel_out
);
    import lpc_pkg::*;

    // configuration registers
    logic [13:0]        r_blend_control;
    logic [15:0]        r_blend_alpha;
    logic [4:0]         r_blend_brightness;
    logic [COLOR_W-1:0] r_backdrop;

    // input register stage
    logic                              r_v1;
    logic [NUM_BG*COLOR_W-1:0]         r_bg_colors;
    logic [NUM_BG*PRIO_W-1:0]          r_bg_prio;
    logic [NUM_BG-1:0]                 r_bg_opaque;
    logic [NUM_OBJ*COLOR_W-1:0]        r_obj_colors;
    logic [NUM_OBJ-1:0]                r_obj_opaque;

    // result register stage
    logic               r_v2;
    logic [PIXEL_W-1:0] r_pixel;
    logic [PIXEL_W-1:0] n_pixel;

    logic adv2;
    logic take_in;

    // per-channel arithmetic helpers
    function automatic logic [4:0] clamp16(input logic [4:0] v);
        return (v > COEF_MAX) ? COEF_MAX : v;
    endfunction

    function automatic logic [4:0] mix_ch(input logic [4:0] a, input logic [4:0] b,
                                          input logic [4:0] wa, input logic [4:0] wb);
        logic [10:0] s;
        s = 11'(a) * 11'(wa) + 11'(b) * 11'(wb);
        return (s[10:4] > 7'd31) ? 5'd31 : s[8:4];
    endfunction

    function automatic logic [4:0] shade_ch(input logic [4:0] c, input logic [4:0] evy,
                                            input logic up);
        logic [7:0]  e;
        logic [12:0] p;
        logic [8:0]  t;
        e = {c, 3'b000};
        if (up) begin
            p = 13'(FULL8 - e) * 13'(evy);
            t = 9'(e) + 9'(p[12:4]);
        end else begin
            p = 13'(e) * 13'(evy);
            t = 9'(e) - 9'(p[12:4]);
        end
        return t[7:3];
    endfunction

    // bgr555 to the packed output word, bit 5 stays clear
    function automatic logic [PIXEL_W-1:0] pack(input logic [COLOR_W-1:0] c);
        return {c[4:0], c[9:5], 1'b0, c[14:10]};
    endfunction

    // handshake: result stage loads when empty or being drained
    assign adv2    = !r_v2 || !i_stall;
    assign o_stall = r_v1 && !adv2;
    assign take_in = i_valid && !o_stall;
    assign o_valid     = r_v2;
    assign o_pixel_out = r_pixel;

    // candidate table: backgrounds in slots 0-3, sprites in slots 4-7
    logic [KEY_W-1:0]   cand_key   [NUM_CAND];
    logic [COLOR_W-1:0] cand_col   [NUM_CAND];
    logic [LAYER_W-1:0] cand_layer [NUM_CAND];
    logic [NUM_CAND-1:0] cand_ok;
    logic [NUM_CAND-1:0] is_top;
    logic [NUM_CAND-1:0] is_second;

    always_comb begin
        for (int n = 0; n < NUM_BG; n++) begin
            // rank key: priority, then background flag, then index; lower wins
            cand_key[n]   = {r_bg_prio[PRIO_W*n +: PRIO_W], 2'b10, 2'(n)};
            cand_col[n]   = r_bg_colors[COLOR_W*n +: COLOR_W];
            cand_layer[n] = LAYER_W'(n);
            cand_ok[n]    = r_bg_opaque[n];
        end
        for (int p = 0; p < NUM_OBJ; p++) begin
            cand_key[NUM_BG+p]   = {2'(p), 4'b0000};
            cand_col[NUM_BG+p]   = r_obj_colors[COLOR_W*p +: COLOR_W];
            cand_layer[NUM_BG+p] = SPRITE_LAYER;
            cand_ok[NUM_BG+p]    = r_obj_opaque[p];
        end
    end

    // rank each opaque candidate by counting opaque candidates with a lower key
    always_comb begin
        logic [2:0] rank;
        for (int i = 0; i < NUM_CAND; i++) begin
            rank = 3'd0;
            for (int j = 0; j < NUM_CAND; j++) begin
                rank = rank + 3'(cand_ok[j] && (cand_key[j] < cand_key[i]));
            end
            is_top[i]    = cand_ok[i] && (rank == 3'd0);
            is_second[i] = cand_ok[i] && (rank == 3'd1);
        end
    end

    // one-hot select of top and second pixel, then the effect
    always_comb begin
        logic [COLOR_W-1:0] c1;
        logic [COLOR_W-1:0] c2;
        logic [LAYER_W-1:0] l1;
        logic [LAYER_W-1:0] l2;
        logic [COLOR_W-1:0] color;
        logic               t1;
        logic               t2;
        logic [4:0]         eva;
        logic [4:0]         evb;
        logic [4:0]         evy;
        t_effect            mode;
        c1 = '0;
        c2 = '0;
        l1 = '0;
        l2 = '0;
        for (int i = 0; i < NUM_CAND; i++) begin
            c1 = c1 | (is_top[i]    ? cand_col[i]   : '0);
            l1 = l1 | (is_top[i]    ? cand_layer[i] : '0);
            c2 = c2 | (is_second[i] ? cand_col[i]   : '0);
            l2 = l2 | (is_second[i] ? cand_layer[i] : '0);
        end
        mode = t_effect'(r_blend_control[7:6]);
        // first targets at bits 4:0, second targets at bits 12:8
        t1   = r_blend_control[{1'b0, l1}];
        t2   = r_blend_control[{1'b1, l2}];
        eva  = clamp16(r_blend_alpha[4:0]);
        evb  = clamp16(r_blend_alpha[12:8]);
        evy  = clamp16(r_blend_brightness);
        color = c1;
        case (mode)
            MODE_ALPHA: begin
                if ((|is_second) && t1 && t2) begin
                    for (int k = 0; k < 3; k++) begin
                        color[5*k +: 5] = mix_ch(c1[5*k +: 5], c2[5*k +: 5], eva, evb);
                    end
                end
            end
            MODE_BRIGHTEN: begin
                if (t1) begin
                    for (int k = 0; k < 3; k++) begin
                        color[5*k +: 5] = shade_ch(c1[5*k +: 5], evy, 1'b1);
                    end
                end
            end
            MODE_DARKEN: begin
                if (t1) begin
                    for (int k = 0; k < 3; k++) begin
                        color[5*k +: 5] = shade_ch(c1[5*k +: 5], evy, 1'b0);
                    end
                end
            end
            default: begin
                color = c1;
            end
        endcase
        // nothing opaque: backdrop, no effect
        if (!(|cand_ok)) begin
            color = r_backdrop;
        end
        n_pixel = pack(color);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_control    <= '0;
            r_blend_alpha      <= '0;
            r_blend_brightness <= '0;
            r_backdrop         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLEND_CONTROL:    r_blend_control    <= i_cfg_data[13:0];
                REG_BLEND_ALPHA:      r_blend_alpha      <= i_cfg_data[15:0];
                REG_BLEND_BRIGHTNESS: r_blend_brightness <= i_cfg_data[4:0];
                REG_BACKDROP_COLOR:   r_backdrop         <= i_cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_bg_colors  <= i_bg_colors;
            r_bg_prio    <= i_bg_priorities;
            r_bg_opaque  <= i_bg_opaque;
            r_obj_colors <= i_obj_colors;
            r_obj_opaque <= i_obj_opaque;
        end
        if (adv2 && r_v1) begin
            r_pixel <= n_pixel;
        end
    end

`ifndef SYNTHESIS
    // a valid input stage that is not blocked shows up as a result next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2) |=> o_valid)
        else $error("input stage item did not reach result stage");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // packed word never carries bit 5
    a_bit5_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_out[5] == 1'b0))
        else $error("pixel bit 5 set");

    // an all-transparent pixel gives the backdrop unchanged
    a_backdrop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2 && (r_bg_opaque == '0) && (r_obj_opaque == '0))
        |=> (o_pixel_out == pack($past(r_backdrop))))
        else $error("transparent pixel did not give backdrop");
`endif

endmodule
